>>> src/stu_pkg.sv
`default_nettype none

package stu_pkg;

    // Widths fixed by the field definitions.
    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned RADIX_W  = 6;
    localparam int unsigned OPT_W    = 3;
    localparam int unsigned VALUE_W  = 64;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 6;

    // Characters stop being taken once this many have been consumed.
    localparam logic [31:0] MAX_STRING_LEN = 32'd65535;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RADIX  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OPTION = 1'd1;

    localparam logic [RADIX_W-1:0] RADIX_RESET  = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_AUTO   = 6'd0;
    localparam logic [RADIX_W-1:0] RADIX_OCT    = 6'd8;
    localparam logic [RADIX_W-1:0] RADIX_DEC    = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_HEX    = 6'd16;
    localparam logic [RADIX_W-1:0] RADIX_MAX    = 6'd36;

    // Option bit positions.
    localparam int unsigned OPT_SKIP_SPACE = 0;
    localparam int unsigned OPT_NO_SIGN    = 1;
    localparam int unsigned OPT_NO_HEXPFX  = 2;

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LOW_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOW_X = 8'h78;
    localparam logic [CHAR_W-1:0] CH_LOW_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_BIT = 8'h20;

    typedef enum logic [2:0] {
        PH_SPACE  = 3'd0,
        PH_SIGN   = 3'd1,
        PH_PREFIX = 3'd2,
        PH_XMARK  = 3'd3,
        PH_DIGITS = 3'd4,
        PH_STOP   = 3'd5
    } phase_t;

    typedef struct packed {
        logic                ok;
        logic [RADIX_W-1:0]  value;
    } digit_t;

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) ||
               (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
    endfunction

    // Decodes a character as a digit of base r; ok is low when it is none.
    function automatic digit_t digit_of(input logic [CHAR_W-1:0] c,
                                        input logic [RADIX_W-1:0] r);
        logic [CHAR_W-1:0] low;
        digit_t            d;
        low     = c | CASE_BIT;
        d.ok    = 1'b0;
        d.value = '0;
        if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
            d.ok    = 1'b1;
            d.value = RADIX_W'(c - CH_ZERO);
        end else if ((low >= CH_LOW_A) && (low <= CH_LOW_Z)) begin
            d.ok    = 1'b1;
            d.value = RADIX_W'(low - CH_LOW_A) + RADIX_W'(10);
        end
        if ((r == '0) || (r > RADIX_MAX) || (d.value >= r)) begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

>>> src/string_to_u64_parser.sv
// A transaction carrying the last character is held in the input register, parsed into
// the result stage, then negated if needed into the output stage that drives m_valid.
// Throughput: one character per cycle; the parse stage (digit decode and a 64x6
// multiply-add) takes a character every cycle, and s_ready drops only while a
// last-character transaction waits for both result stages, held full by m_ready low.
// Reset (aresetn low at a clock edge) empties all stages, clears the parse state
// and loads radix 10 and option bits 0.
`default_nettype none

module string_to_u64_parser (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    // configuration write port
    input  wire                                 cfg_wr_en,
    input  wire [stu_pkg::CFG_IDX_W-1:0]        cfg_wr_index,
    input  wire [stu_pkg::CFG_DATA_W-1:0]       cfg_wr_data,
    // character stream
    input  wire                                 s_valid,
    output logic                                s_ready,
    input  wire [stu_pkg::CHAR_W-1:0]           s_char_code,
    input  wire                                 s_char_present,
    input  wire                                 s_last_char,
    // parsed results
    output logic                                m_valid,
    input  wire                                 m_ready,
    output logic [stu_pkg::VALUE_W-1:0]         m_value,
    output logic [stu_pkg::LEN_W-1:0]           m_number_length
);
    import stu_pkg::*;

    // Configuration registers.
    logic [RADIX_W-1:0] radix_reg;
    logic [OPT_W-1:0]   option_reg;

    // Input register stage: holds one accepted transaction.
    logic               in_valid_reg;
    logic [CHAR_W-1:0]  in_char_reg;
    logic               in_present_reg;
    logic               in_last_reg;

    // Parse state, updated once per character.
    phase_t             phase_reg, phase_next;
    logic [RADIX_W-1:0] active_radix_reg, active_radix_next;
    logic               negate_reg, negate_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic [LEN_W-1:0]   count_reg, count_next;

    // Result stage: raw accumulator and sign of a finished string.
    logic               res_valid_reg;
    logic [VALUE_W-1:0] res_acc_reg;
    logic               res_negate_reg;
    logic [LEN_W-1:0]   res_len_reg;

    // Output stage: final two's complement value.
    logic               out_valid_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic [LEN_W-1:0]   out_len_reg;

    logic out_load;
    logic res_free;
    logic in_fire;

    // Ready flows backward: each stage may load when it is empty or is
    // being emptied in the same cycle.
    assign out_load = res_valid_reg && (!out_valid_reg || m_ready);
    assign res_free = !res_valid_reg || out_load;
    // A character that does not end the string never needs the result stage.
    assign in_fire  = in_valid_reg && (!in_last_reg || res_free);
    assign s_ready  = !in_valid_reg || in_fire;

    assign m_valid         = out_valid_reg;
    assign m_value         = out_value_reg;
    assign m_number_length = out_len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg  <= RADIX_RESET;
            option_reg <= '0;
        end else if (cfg_wr_en) begin
            if (cfg_wr_index == CFG_RADIX) begin
                radix_reg <= cfg_wr_data[RADIX_W-1:0];
            end else if (cfg_wr_index == CFG_OPTION) begin
                option_reg <= cfg_wr_data[OPT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_char_reg    <= s_char_code;
            in_present_reg <= s_char_present;
            in_last_reg    <= s_last_char;
        end
    end

    // Parse step. The phase chain falls through at most once per phase
    // (whitespace, sign, prefix, x mark, digits) before the character is either
    // taken or rejected, so the loop of the algorithm flattens to a short
    // cascade. The length check uses the count before this character, which
    // no fall-through step changes.
    always_comb begin
        phase_t             ph;
        logic [RADIX_W-1:0] ar;
        logic               neg;
        logic [VALUE_W-1:0] acc;
        logic               take;
        logic               done;
        digit_t             dg;

        ph   = phase_reg;
        ar   = active_radix_reg;
        neg  = negate_reg;
        acc  = acc_reg;
        take = 1'b0;
        done = 1'b0;
        dg   = digit_of(in_char_reg, active_radix_reg);

        if (in_present_reg) begin
            if ((ph != PH_STOP) && ({{(32-LEN_W){1'b0}}, count_reg} >= MAX_STRING_LEN)) begin
                ph   = PH_STOP;
                done = 1'b1;
            end

            if (!done && (ph == PH_SPACE)) begin
                if (option_reg[OPT_SKIP_SPACE] && is_space(in_char_reg)) begin
                    take = 1'b1;
                    done = 1'b1;
                end else begin
                    ph = PH_SIGN;
                end
            end

            if (!done && (ph == PH_SIGN)) begin
                ph = PH_PREFIX;
                if (!option_reg[OPT_NO_SIGN]) begin
                    if (in_char_reg == CH_MINUS) begin
                        neg  = 1'b1;
                        take = 1'b1;
                        done = 1'b1;
                    end else if (in_char_reg == CH_PLUS) begin
                        take = 1'b1;
                        done = 1'b1;
                    end
                end
            end

            if (!done && (ph == PH_PREFIX)) begin
                ph = PH_DIGITS;
                if (radix_reg == RADIX_AUTO) begin
                    ar = RADIX_DEC;
                    if (in_char_reg == CH_ZERO) begin
                        ar   = RADIX_OCT;
                        ph   = PH_XMARK;
                        take = 1'b1;
                        done = 1'b1;
                    end
                end else if ((radix_reg == RADIX_HEX) && !option_reg[OPT_NO_HEXPFX]) begin
                    ar = RADIX_HEX;
                    if (in_char_reg == CH_ZERO) begin
                        ph   = PH_XMARK;
                        take = 1'b1;
                        done = 1'b1;
                    end
                end else begin
                    ar = radix_reg;
                end
                // The digit step below must see the base chosen just now.
                dg = digit_of(in_char_reg, ar);
            end

            if (!done && (ph == PH_XMARK)) begin
                ph = PH_DIGITS;
                if (in_char_reg == CH_LOW_X) begin
                    ar   = RADIX_HEX;
                    take = 1'b1;
                    done = 1'b1;
                end
            end

            if (!done && (ph == PH_DIGITS)) begin
                done = 1'b1;
                if (dg.ok) begin
                    acc  = (acc * VALUE_W'(ar)) + VALUE_W'(dg.value);
                    take = 1'b1;
                end else begin
                    ph = PH_STOP;
                end
            end

            if (!done) begin
                ph = PH_STOP;
            end
        end

        phase_next        = ph;
        active_radix_next = ar;
        negate_next       = neg;
        acc_next          = acc;
        count_next        = count_reg;
        if (take && (count_reg != {LEN_W{1'b1}})) begin
            count_next = count_reg + LEN_W'(1);
        end
    end

    // A string ends with its last transaction: the result is captured and
    // the parse state returns to its start for the next string.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_SPACE;
            active_radix_reg <= '0;
            negate_reg       <= 1'b0;
            acc_reg          <= '0;
            count_reg        <= '0;
        end else if (in_fire) begin
            if (in_last_reg) begin
                phase_reg        <= PH_SPACE;
                active_radix_reg <= '0;
                negate_reg       <= 1'b0;
                acc_reg          <= '0;
                count_reg        <= '0;
            end else begin
                phase_reg        <= phase_next;
                active_radix_reg <= active_radix_next;
                negate_reg       <= negate_next;
                acc_reg          <= acc_next;
                count_reg        <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (res_free) begin
            res_valid_reg <= in_fire && in_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && in_last_reg) begin
            res_acc_reg    <= acc_next;
            res_negate_reg <= negate_next;
            res_len_reg    <= count_next;
        end
    end

    // The negation sits in its own stage so it does not follow the
    // multiply-add in the same cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg <= res_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_value_reg <= res_negate_reg ? (~res_acc_reg + VALUE_W'(1)) : res_acc_reg;
            out_len_reg   <= res_len_reg;
        end
    end

endmodule

`default_nettype wire
